// File: rtl/ctl_pkg.sv
// Shared types and constants of the configuration token lexer.
package ctl_pkg;

  // Token type codes as they appear on the result channel.
  typedef enum logic [3:0] {
    TOK_ID      = 4'd0,
    TOK_IPV4    = 4'd1,
    TOK_DOMAIN  = 4'd2,
    TOK_STRING  = 4'd3,
    TOK_LBRACK  = 4'd4,
    TOK_RBRACK  = 4'd5,
    TOK_COLON   = 4'd6,
    TOK_NEWLINE = 4'd7,
    TOK_END     = 4'd8,
    TOK_ERROR   = 4'd9
  } tok_e;

  // Character classes produced by the front end.
  typedef enum logic [3:0] {
    K_LBRACK,
    K_RBRACK,
    K_COLON,
    K_NEWLINE,
    K_BLANK,
    K_DIGIT,
    K_ALPHA,
    K_QUOTE,
    K_DOT,
    K_HYPHEN,
    K_OTHER
  } kind_e;

  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_HYPHEN  = 8'h2D;

  localparam int          LenW       = 16;
  localparam logic [7:0]  LimitReset = 8'd255;
  localparam logic [9:0]  OctetMax   = 10'd255;

  // Output buffer depth; must stay a power of two so the pointers wrap.
  localparam int OutDepth = 4;
  localparam int OutPtrW  = $clog2(OutDepth);
  localparam int OutCntW  = $clog2(OutDepth + 1);

  // One classified input word.
  typedef struct packed {
    logic       eoi;
    kind_e      kind;
    logic       punct;
    logic [3:0] digit;
  } class_t;

  // One result word.
  typedef struct packed {
    tok_e            token_type;
    logic [LenW-1:0] token_length;
    logic            last;
  } res_t;

  // Up to two results caused by one input word, slot 0 first.
  typedef struct packed {
    logic v0;
    res_t r0;
    logic v1;
    res_t r1;
  } res_pair_t;

endpackage

// File: rtl/ctl_if.sv
// Handshake interfaces for the character and token channels.
interface ctl_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       end_of_input;

  modport source(output valid, character, end_of_input, input ready);
  modport sink(input valid, character, end_of_input, output ready);
endinterface

interface ctl_tok_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_type;
  logic [15:0] token_length;
  logic        last;

  modport source(output valid, token_type, token_length, last, input ready);
  modport sink(input valid, token_type, token_length, last, output ready);
endinterface

// File: rtl/ctl_front.sv
// Front end: classifies incoming characters and queues them for the lexer.
module ctl_front
  import ctl_pkg::*;
#(
  parameter int Depth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ctl_char_if.sink   in_i,
  output class_t     head_o,
  output logic       head_valid_o,
  input  logic       head_pop_i
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  class_t        mem [Depth];
  logic [AW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          push, pop;

  function automatic class_t classify(logic [7:0] c, logic eoi);
    class_t r;
    r.eoi   = eoi;
    r.digit = c[3:0];
    r.punct = (c inside {[8'd33:8'd47], [8'd58:8'd64], [8'd91:8'd96], [8'd123:8'd126]});
    if (c == CH_LBRACK) r.kind = K_LBRACK;
    else if (c == CH_RBRACK) r.kind = K_RBRACK;
    else if (c == CH_COLON) r.kind = K_COLON;
    else if (c == CH_NEWLINE) r.kind = K_NEWLINE;
    else if (c == CH_SPACE || c == CH_TAB) r.kind = K_BLANK;
    else if (c inside {[8'h30:8'h39]}) r.kind = K_DIGIT;
    else if (c inside {[8'h41:8'h5A], [8'h61:8'h7A]}) r.kind = K_ALPHA;
    else if (c == CH_QUOTE) r.kind = K_QUOTE;
    else if (c == CH_DOT) r.kind = K_DOT;
    else if (c == CH_HYPHEN) r.kind = K_HYPHEN;
    else r.kind = K_OTHER;
    return r;
  endfunction

  function automatic logic [AW-1:0] ptr_inc(logic [AW-1:0] p);
    return (p == AW'(Depth - 1)) ? '0 : p + AW'(1);
  endfunction

  assign in_i.ready   = (cnt_q != CW'(Depth));
  assign push         = in_i.valid & in_i.ready;
  assign head_valid_o = (cnt_q != '0);
  assign pop          = head_pop_i & head_valid_o;
  assign head_o       = mem[rp_q];

  always_comb begin
    wp_d  = push ? ptr_inc(wp_q) : wp_q;
    rp_d  = pop ? ptr_inc(rp_q) : rp_q;
    cnt_d = cnt_q + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem[wp_q] <= classify(in_i.character, in_i.end_of_input);
    end
  end

endmodule

// File: rtl/ctl_back.sv
// Back end: the lexer state machine that turns classified words into tokens.
module ctl_back
  import ctl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       limit_we_i,
  input  logic [7:0] limit_i,
  input  class_t     head_i,
  input  logic       head_valid_i,
  output logic       head_pop_o,
  input  logic       space_i,
  output res_pair_t  res_o
);

  typedef enum logic [2:0] {
    M_IDLE,
    M_IPV4,
    M_STR,
    M_WORD,
    M_ERR
  } mode_e;

  typedef struct packed {
    mode_e           mode;
    logic [LenW-1:0] count;
    logic            id_ok;
    logic            dom_ok;
    logic            label_start;
    logic [1:0]      oct_idx;
    logic [1:0]      oct_digits;
    logic [9:0]      oct_value;
    logic            ip_ok;
  } lex_st_t;

  localparam lex_st_t Cleared = '{
    mode: M_IDLE, count: '0, id_ok: 1'b1, dom_ok: 1'b1, label_start: 1'b1,
    oct_idx: '0, oct_digits: '0, oct_value: '0, ip_ok: 1'b1
  };

  lex_st_t    st_q, st_d;
  logic [7:0] limit_q;

  function automatic logic [LenW-1:0] sat_inc(logic [LenW-1:0] v);
    return (v == '1) ? v : v + LenW'(1);
  endfunction

  function automatic lex_st_t feed_ipv4(lex_st_t s, class_t it);
    lex_st_t r;
    r       = s;
    r.count = sat_inc(s.count);
    if (s.ip_ok) begin
      if (it.kind == K_DIGIT) begin
        if (s.oct_digits == 2'd3) begin
          r.ip_ok = 1'b0;
        end else begin
          r.oct_value  = 10'(s.oct_value * 10'd10 + 10'(it.digit));
          r.oct_digits = s.oct_digits + 2'd1;
        end
      end else if (it.kind == K_DOT) begin
        if (s.oct_digits == '0 || s.oct_value > OctetMax || s.oct_idx == 2'd3) begin
          r.ip_ok = 1'b0;
        end else begin
          r.oct_idx    = s.oct_idx + 2'd1;
          r.oct_digits = '0;
          r.oct_value  = '0;
        end
      end else begin
        r.ip_ok = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic lex_st_t feed_word(lex_st_t s, class_t it, logic [7:0] lim);
    lex_st_t r;
    r       = s;
    r.count = sat_inc(s.count);
    if (it.punct) r.id_ok = 1'b0;
    if (s.dom_ok) begin
      if (r.count >= LenW'(lim)) begin
        r.dom_ok = 1'b0;
      end else if (s.label_start && (it.kind == K_DOT || it.kind == K_HYPHEN)) begin
        r.dom_ok = 1'b0;
      end else if (it.kind == K_DIGIT || it.kind == K_ALPHA || it.kind == K_HYPHEN) begin
        r.label_start = 1'b0;
      end else if (it.kind == K_DOT) begin
        r.label_start = 1'b1;
      end else begin
        r.dom_ok = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic tok_e pending_type(lex_st_t s);
    tok_e t;
    t = TOK_ERROR;
    if (s.mode == M_IPV4) begin
      if (s.ip_ok && s.oct_idx == 2'd3 && s.oct_digits != '0 && s.oct_value <= OctetMax)
        t = TOK_IPV4;
    end else if (s.mode == M_WORD) begin
      if (s.id_ok) t = TOK_ID;
      else if (s.dom_ok) t = TOK_DOMAIN;
    end
    return t;
  endfunction

  logic      delim;
  logic      own_v;
  res_t      own, pend;
  lex_st_t   start;
  res_pair_t res;

  assign head_pop_o = head_valid_i & space_i;

  always_comb begin
    st_d  = st_q;
    res   = '0;
    own_v = 1'b0;
    own   = '0;
    pend  = '{token_type: pending_type(st_q), token_length: st_q.count, last: 1'b0};
    start = Cleared;
    delim = head_i.eoi || (head_i.kind inside {K_LBRACK, K_RBRACK, K_COLON, K_NEWLINE,
                                               K_BLANK});
    if (st_q.mode == M_STR) begin
      if (head_i.eoi) begin
        res.v0 = 1'b1;
        res.r0 = '{token_type: TOK_ERROR, token_length: st_q.count, last: 1'b0};
        res.v1 = 1'b1;
        res.r1 = '{token_type: TOK_END, token_length: '0, last: 1'b0};
        st_d   = Cleared;
      end else if (head_i.kind == K_QUOTE) begin
        res.v0 = 1'b1;
        res.r0 = '{token_type: TOK_STRING, token_length: sat_inc(st_q.count), last: 1'b0};
        st_d   = Cleared;
      end else begin
        st_d.count = sat_inc(st_q.count);
      end
    end else if (st_q.mode != M_IDLE && !delim) begin
      if (st_q.mode == M_IPV4) st_d = feed_ipv4(st_q, head_i);
      else if (st_q.mode == M_WORD) st_d = feed_word(st_q, head_i, limit_q);
      else st_d.count = sat_inc(st_q.count);
    end else begin
      // Close any pending token, then handle the word from a cleared state.
      st_d = Cleared;
      if (head_i.eoi) begin
        own_v = 1'b1;
        own   = '{token_type: TOK_END, token_length: '0, last: 1'b0};
      end else begin
        case (head_i.kind)
          K_LBRACK: begin
            own_v = 1'b1;
            own   = '{token_type: TOK_LBRACK, token_length: LenW'(1), last: 1'b0};
          end
          K_RBRACK: begin
            own_v = 1'b1;
            own   = '{token_type: TOK_RBRACK, token_length: LenW'(1), last: 1'b0};
          end
          K_COLON: begin
            own_v = 1'b1;
            own   = '{token_type: TOK_COLON, token_length: LenW'(1), last: 1'b0};
          end
          K_NEWLINE: begin
            own_v = 1'b1;
            own   = '{token_type: TOK_NEWLINE, token_length: LenW'(1), last: 1'b0};
          end
          K_BLANK: begin
            st_d = Cleared;
          end
          K_DIGIT: begin
            start.mode = M_IPV4;
            st_d       = feed_ipv4(start, head_i);
          end
          K_QUOTE: begin
            st_d.mode  = M_STR;
            st_d.count = LenW'(1);
          end
          K_ALPHA: begin
            start.mode = M_WORD;
            st_d       = feed_word(start, head_i, limit_q);
          end
          default: begin
            st_d.mode  = M_ERR;
            st_d.count = LenW'(1);
          end
        endcase
      end
      if (st_q.mode != M_IDLE) begin
        res.v0 = 1'b1;
        res.r0 = pend;
        res.v1 = own_v;
        res.r1 = own;
      end else begin
        res.v0 = own_v;
        res.r0 = own;
      end
    end
    if (res.v1) res.r1.last = 1'b1;
    else if (res.v0) res.r0.last = 1'b1;
    res.v0 = res.v0 & head_pop_o;
    res.v1 = res.v1 & head_pop_o;
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= Cleared;
      limit_q <= LimitReset;
    end else begin
      if (head_pop_o) st_q <= st_d;
      if (limit_we_i) limit_q <= limit_i;
    end
  end

endmodule

// File: rtl/ctl_outq.sv
// Output buffer: takes up to two tokens per cycle and hands them out one at a time.
module ctl_outq
  import ctl_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  res_pair_t wr_i,
  output logic      space_o,
  ctl_tok_if.source out_o
);

  res_t               mem [OutDepth];
  logic [OutPtrW-1:0] wp_q, rp_q;
  logic [OutCntW-1:0] cnt_q;
  logic               pop;
  res_t               head;

  assign space_o      = (cnt_q <= OutCntW'(OutDepth - 2));
  assign out_o.valid  = (cnt_q != '0);
  assign pop          = out_o.valid & out_o.ready;
  assign head         = mem[rp_q];
  assign out_o.token_type   = head.token_type;
  assign out_o.token_length = head.token_length;
  assign out_o.last         = head.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + OutPtrW'(wr_i.v0) + OutPtrW'(wr_i.v1);
      rp_q  <= rp_q + OutPtrW'(pop);
      cnt_q <= cnt_q + OutCntW'(wr_i.v0) + OutCntW'(wr_i.v1) - OutCntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.v0) mem[wp_q] <= wr_i.r0;
    if (wr_i.v1) mem[wp_q + OutPtrW'(1)] <= wr_i.r1;
  end

endmodule

// File: rtl/config_token_lexer.sv
// Top level of the configuration token lexer: front end, lexer and output buffer.
//
// Usage: characters arrive on in_i, one word per accepted handshake, each word
// carrying one byte or an end-of-input mark. Tokens leave on out_o as words of
// type and length; last marks the final token caused by one input word, and an
// input word causes at most two tokens. The domain length limit is written
// through domain_length_limit_we_i and domain_length_limit_i; the user must do
// so only while idle, as the block does not enforce it. Path: an accepted word
// is stored in the front queue, the lexer turns it into tokens combinationally
// and they are registered into the output buffer that drives out_o. Throughput:
// one input word per cycle while the output buffer has room for two tokens, as
// set by the lexer state update; a word's two tokens leave one at a time. Reset:
// the lexer goes idle between tokens, the limit returns to 255 and both queues
// empty. When the receiver stalls, the output buffer fills, the lexer stops
// taking words, and in_i.ready falls once QueueDepth words are queued.
module config_token_lexer
  import ctl_pkg::*;
#(
  parameter int QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       domain_length_limit_we_i,
  input  logic [7:0] domain_length_limit_i,
  ctl_char_if.sink   in_i,
  ctl_tok_if.source  out_o
);

  // Classified words waiting for the lexer.
  class_t    head;
  logic      head_valid;
  logic      head_pop;

  // Tokens from the lexer and the room left in the output buffer.
  res_pair_t res;
  logic      space;

  ctl_front #(
    .Depth(QueueDepth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .head_o      (head),
    .head_valid_o(head_valid),
    .head_pop_i  (head_pop)
  );

  // The lexer only advances when the output buffer can take two tokens, so a
  // word is never half processed.
  ctl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .limit_we_i  (domain_length_limit_we_i),
    .limit_i     (domain_length_limit_i),
    .head_i      (head),
    .head_valid_i(head_valid),
    .head_pop_o  (head_pop),
    .space_i     (space),
    .res_o       (res)
  );

  ctl_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (res),
    .space_o(space),
    .out_o  (out_o)
  );

endmodule

// File: tb/config_token_lexer_tb.sv
// Self-checking testbench for the configuration token lexer.
`timescale 1ns / 1ps

module config_token_lexer_tb;
  import ctl_pkg::*;

  // The lexer never waits this long without a handshake on either channel.
  // Sender gaps and receiver stalls are bounded by idle_len.
  localparam int QuietLimit = 2000;
  // Cycles allowed after the last expected token before the lexer counts as idle.
  // Words that close no token may still sit in the front queue by then.
  localparam int SettleCycles = 12;
  // Input words in the random part of each limit setting.
  localparam int PhaseWords = 30;
  localparam logic [7:0] CH_BACKTICK = 8'h60;

  // Lexer modes of the predictor; the block's own encoding stays inside it.
  typedef enum logic [2:0] {
    LX_IDLE,
    LX_IPV4,
    LX_STRING,
    LX_WORD,
    LX_ERROR
  } lex_mode_e;

  // One word for the character channel.
  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
  } char_word_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       limit_we;
  logic [7:0] limit_data;

  ctl_char_if char_if ();
  ctl_tok_if  tok_if ();

  config_token_lexer u_dut (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .domain_length_limit_we_i(limit_we),
    .domain_length_limit_i   (limit_data),
    .in_i                    (char_if),
    .out_o                   (tok_if)
  );

  always #5 clk_i = ~clk_i;

  // Words waiting to be driven, and tokens that accepted words have caused.
  char_word_t char_q[$];
  res_t       pending_tokens[$];

  // Predictor state: a copy of the lexer's running flags and the limit register.
  lex_mode_e   mode;
  logic [15:0] tok_len;
  logic        id_ok;
  logic        dom_ok;
  logic        lab_start;
  logic [2:0]  oct_idx;
  logic [1:0]  oct_dig;
  logic [9:0]  oct_val;
  logic        ip_ok;
  logic [7:0]  lim = LimitReset;

  int mismatches;
  int words_taken;
  int tokens_seen;
  int limits_used = 1;
  int send_gap;
  int feed_burst;
  int stall_left;
  int take_burst;
  int quiet_cycles;
  res_t want;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  // ASCII punctuation; any other byte keeps a letter token an identifier.
  function automatic logic is_punct(input logic [7:0] c);
    return (c >= "!" && c <= "/") || (c >= ":" && c <= "@") ||
           (c >= "[" && c <= CH_BACKTICK) || (c >= "{" && c <= "~");
  endfunction

  function automatic void clear_token();
    mode      = LX_IDLE;
    tok_len   = '0;
    id_ok     = 1'b1;
    dom_ok    = 1'b1;
    lab_start = 1'b1;
    oct_idx   = '0;
    oct_dig   = '0;
    oct_val   = '0;
    ip_ok     = 1'b1;
  endfunction

  // Token lengths stick at the top of the 16-bit range.
  function automatic void bump();
    if (tok_len != 16'hFFFF) tok_len++;
  endfunction

  function automatic res_t make_token(input tok_e t, input logic [15:0] len);
    res_t r;
    r.token_type   = t;
    r.token_length = len;
    r.last         = 1'b0;
    return r;
  endfunction

  // A digit-led token: four groups of one to three digits, each at most 255.
  // A group's value is only judged at the dot that ends it or at the close.
  function automatic void feed_ipv4(input logic [7:0] c);
    bump();
    if (ip_ok) begin
      if (is_digit(c)) begin
        if (oct_dig == 2'd3) begin
          ip_ok = 1'b0;
        end else begin
          oct_val = 10'(oct_val * 10 + (c - "0"));
          oct_dig++;
        end
      end else if (c == CH_DOT) begin
        if (oct_dig == 0 || oct_val > OctetMax || oct_idx >= 3) begin
          ip_ok = 1'b0;
        end else begin
          oct_idx++;
          oct_dig = '0;
          oct_val = '0;
        end
      end else begin
        ip_ok = 1'b0;
      end
    end
  endfunction

  // A letter-led token tracks two readings at once: identifier and domain.
  // The domain reading also fails once the length reaches the limit register.
  function automatic void feed_word(input logic [7:0] c);
    bump();
    if (is_punct(c)) id_ok = 1'b0;
    if (dom_ok) begin
      if (tok_len >= 16'(lim)) begin
        dom_ok = 1'b0;
      end else if (lab_start && (c == CH_DOT || c == CH_HYPHEN)) begin
        dom_ok = 1'b0;
      end else if (is_digit(c) || is_alpha(c) || c == CH_HYPHEN) begin
        lab_start = 1'b0;
      end else if (c == CH_DOT) begin
        lab_start = 1'b1;
      end else begin
        dom_ok = 1'b0;
      end
    end
  endfunction

  // Type of the token that a delimiter closes.
  function automatic tok_e closing_type();
    if (mode == LX_IPV4) begin
      return (ip_ok && oct_idx == 3 && oct_dig != 0 && oct_val <= OctetMax) ?
             TOK_IPV4 : TOK_ERROR;
    end
    if (mode == LX_WORD) return id_ok ? TOK_ID : (dom_ok ? TOK_DOMAIN : TOK_ERROR);
    return TOK_ERROR;
  endfunction

  // Advances the predictor by one accepted word and queues the tokens it causes:
  // at most a closed token followed by the delimiter's own token.
  function automatic void lex_step(input logic [7:0] c, input logic eoi);
    res_t made[2];
    int   n;
    logic delim;
    n     = 0;
    delim = eoi || c == CH_LBRACK || c == CH_RBRACK || c == CH_COLON ||
            c == CH_SPACE || c == CH_TAB || c == CH_NEWLINE;
    if (mode == LX_STRING) begin
      // Inside quotes only the closing quote or the end of input matter.
      if (eoi) begin
        made[n++] = make_token(TOK_ERROR, tok_len);
        clear_token();
        made[n++] = make_token(TOK_END, '0);
      end else begin
        bump();
        if (c == CH_QUOTE) begin
          made[n++] = make_token(TOK_STRING, tok_len);
          clear_token();
        end
      end
    end else if (mode != LX_IDLE && !delim) begin
      case (mode)
        LX_IPV4: feed_ipv4(c);
        LX_WORD: feed_word(c);
        default: bump();
      endcase
    end else begin
      if (mode != LX_IDLE) begin
        made[n++] = make_token(closing_type(), tok_len);
        clear_token();
      end
      if (eoi) begin
        made[n++] = make_token(TOK_END, '0);
      end else if (c == CH_LBRACK) begin
        made[n++] = make_token(TOK_LBRACK, 16'd1);
      end else if (c == CH_RBRACK) begin
        made[n++] = make_token(TOK_RBRACK, 16'd1);
      end else if (c == CH_COLON) begin
        made[n++] = make_token(TOK_COLON, 16'd1);
      end else if (c == CH_NEWLINE) begin
        made[n++] = make_token(TOK_NEWLINE, 16'd1);
      end else if (c == CH_SPACE || c == CH_TAB) begin
        // Blanks between tokens produce nothing.
      end else if (is_digit(c)) begin
        mode = LX_IPV4;
        feed_ipv4(c);
      end else if (c == CH_QUOTE) begin
        mode = LX_STRING;
        bump();
      end else if (is_alpha(c)) begin
        mode = LX_WORD;
        feed_word(c);
      end else begin
        mode = LX_ERROR;
        bump();
      end
    end
    for (int k = 0; k < n; k++) begin
      made[k].last = (k == n - 1);
      pending_tokens.push_back(made[k]);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void push_byte(input logic [7:0] b);
    char_q.push_back('{ch: b, eoi: 1'b0});
  endfunction

  // The byte that rides along with an end mark is ignored but still driven.
  function automatic void push_end(input logic [7:0] b);
    char_q.push_back('{ch: b, eoi: 1'b1});
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  function automatic logic [7:0] letter();
    return ($urandom_range(0, 1) ? "a" : "A") + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] alnum();
    return $urandom_range(0, 2) ? letter() : "0" + 8'($urandom_range(0, 9));
  endfunction

  // Dotted quads, mostly valid; the rest carry one flaw: a wrong group count or one bad group.
  function automatic void gen_ipv4();
    int groups;
    int flaw;
    int bad_g;
    int v;
    flaw   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
    groups = (flaw == 1) ? ($urandom_range(0, 1) ? 3 : 5) : 4;
    bad_g  = $urandom_range(0, groups - 1);
    for (int g = 0; g < groups; g++) begin
      if (g != 0) push_byte(CH_DOT);
      v = $urandom_range(0, 255);
      if (g == bad_g && flaw == 2) begin
        push_text($sformatf("%0d", $urandom_range(256, 999)));
      end else if (g == bad_g && flaw == 3) begin
        push_text($sformatf("%04d", v));
      end else if (g == bad_g && flaw == 4) begin
        // Empty group: two dots in a row, a leading dot when first, or a trailing dot when last.
      end else if (g == bad_g && flaw == 5) begin
        push_text($sformatf("%0d", v));
        push_byte(letter());
      end else if ($urandom_range(0, 4) == 0) begin
        push_text($sformatf("%03d", v));
      end else begin
        push_text($sformatf("%0d", v));
      end
    end
  endfunction

  // Identifiers: letters and digits, now and then a high or control byte
  // (still an identifier) or an underscore (punctuation, so an error).
  function automatic void gen_word();
    int len;
    int r;
    push_byte(letter());
    len = $urandom_range(0, 10);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 19);
      if (r == 0) push_byte(8'($urandom_range(128, 255)));
      else if (r == 1) push_byte(8'($urandom_range(11, 31)));
      else if (r == 2) push_byte("_");
      else push_byte(alnum());
    end
  endfunction

  // Domains: labels of letters, digits and hyphens joined by dots.
  function automatic void gen_domain();
    int labels;
    int len;
    int flaw;
    labels = $urandom_range(1, 4);
    flaw   = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 4) : 0;
    push_byte(letter());
    for (int l = 0; l < labels; l++) begin
      if (l != 0) begin
        push_byte(CH_DOT);
        if (flaw == 1 && l == labels - 1) push_byte(CH_DOT);
        if (flaw == 2 && l == labels - 1) push_byte(CH_HYPHEN);
        push_byte(alnum());
      end
      len = $urandom_range(0, 12);
      for (int i = 0; i < len; i++) push_byte($urandom_range(0, 5) ? alnum() : CH_HYPHEN);
    end
    // A lone label needs a hyphen to read as a domain instead of an identifier.
    if (labels == 1) push_byte(CH_HYPHEN);
    if (flaw == 3) push_byte($urandom_range(0, 1) ? "@" : "_");
    if (flaw == 4 || $urandom_range(0, 5) == 0) push_byte(CH_DOT);
  endfunction

  // Quoted strings with arbitrary bytes inside, delimiters among them.
  // Some are cut short by the end of input.
  function automatic void gen_string();
    int len;
    logic [7:0] b;
    push_byte(CH_QUOTE);
    len = $urandom_range(0, 10);
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      push_byte(b == CH_QUOTE ? "q" : b);
    end
    if ($urandom_range(0, 9) == 0) push_end(8'($urandom_range(0, 255)));
    else push_byte(CH_QUOTE);
  endfunction

  function automatic void gen_delim();
    case ($urandom_range(0, 6))
      0: push_byte(CH_LBRACK);
      1: push_byte(CH_RBRACK);
      2: push_byte(CH_COLON);
      3: push_byte(CH_NEWLINE);
      4: push_byte(CH_TAB);
      default: repeat ($urandom_range(1, 4)) push_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    endcase
  endfunction

  // Random part of one limit setting: mostly well-formed tokens separated by
  // delimiters, some glued together, some noise bytes and stray end marks.
  function automatic void gen_random(input int words);
    int r;
    while (char_q.size() < words) begin
      r = $urandom_range(0, 99);
      if (r < 20) gen_ipv4();
      else if (r < 38) gen_word();
      else if (r < 56) gen_domain();
      else if (r < 66) gen_string();
      else if (r < 90) gen_delim();
      else if (r < 97) push_byte(8'($urandom_range(0, 255)));
      else push_end(8'($urandom_range(0, 255)));
      if (r < 66 && $urandom_range(0, 6) != 0) gen_delim();
    end
    // Leave the lexer between tokens before the limit changes again.
    push_end(8'($urandom_range(0, 255)));
  endfunction

  // Domains just under and at the top limit.
  function automatic void gen_long_tokens();
    push_text("a.");
    repeat (252) push_byte("b");
    push_byte(CH_SPACE);
    push_text("a.");
    repeat (253) push_byte("b");
    push_byte(CH_NEWLINE);
    push_end(8'h00);
  endfunction

  // Idle length for either channel: mostly none or short, a few long, and
  // now and then a burst of back-to-back cycles.
  function automatic int idle_len(inout int burst);
    int r;
    if (burst != 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst = $urandom_range(20, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver, receiver, monitor and watchdog
  // ---------------------------------------------------------------------------

  // Character driver: the current word holds until accepted, then a gap may
  // follow before the next word from the queue.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_if.valid <= 1'b0;
      send_gap      <= 0;
    end else if (!char_if.valid || char_if.ready) begin
      if (send_gap != 0) begin
        char_if.valid <= 1'b0;
        send_gap      <= send_gap - 1;
      end else if (char_q.size() != 0) begin
        char_if.valid        <= 1'b1;
        char_if.character    <= char_q[0].ch;
        char_if.end_of_input <= char_q[0].eoi;
        void'(char_q.pop_front());
        send_gap <= idle_len(feed_burst);
      end else begin
        char_if.valid <= 1'b0;
      end
    end
  end

  // Token receiver: ready drops for random stretches.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_if.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left != 0) begin
      tok_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      tok_if.ready <= 1'b1;
      stall_left   <= idle_len(take_burst);
    end
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  // Both channels are sampled at the rising edge, before this edge's updates
  // land. A token cannot come out at the edge that accepts its input word,
  // so checking before predicting is safe.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (tok_if.valid && tok_if.ready) begin
        tokens_seen++;
        if (pending_tokens.size() == 0) begin
          report_mismatch($sformatf("unexpected token type %0d length %0d last %0b",
                                    tok_if.token_type, tok_if.token_length, tok_if.last));
        end else begin
          want = pending_tokens.pop_front();
          if (tok_if.token_type !== want.token_type)
            report_mismatch($sformatf("token %0d type %0d, expected %0d", tokens_seen,
                                      tok_if.token_type, want.token_type));
          if (tok_if.token_length !== want.token_length)
            report_mismatch($sformatf("token %0d length %0d, expected %0d", tokens_seen,
                                      tok_if.token_length, want.token_length));
          if (tok_if.last !== want.last)
            report_mismatch($sformatf("token %0d last %0b, expected %0b", tokens_seen,
                                      tok_if.last, want.last));
        end
      end
      if (char_if.valid && char_if.ready) begin
        words_taken++;
        lex_step(char_if.character, char_if.end_of_input);
      end
    end
  end

  // Ends the run when neither channel moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (char_if.valid && char_if.ready) || (tok_if.valid && tok_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("[%0t] no handshake for %0d cycles, %0d tokens outstanding",
               $time, QuietLimit, pending_tokens.size());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  // Waits until every word is sent and every expected token has arrived,
  // then lets words that close no token drain out of the block. Queue state
  // is read at the falling edge, away from the monitor's updates.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (char_q.size() != 0 || char_if.valid || pending_tokens.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Called right after a rising edge; the write lands at the next one.
  task automatic write_limit(input logic [7:0] v);
    limit_we   <= 1'b1;
    limit_data <= v;
    @(posedge clk_i);
    limit_we <= 1'b0;
    lim = v;
    limits_used++;
  endtask

  initial begin
    logic [7:0] limits[6];
    char_if.valid        = 1'b0;
    char_if.character    = '0;
    char_if.end_of_input = 1'b0;
    tok_if.ready         = 1'b0;
    limit_we             = 1'b0;
    limit_data           = '0;
    clear_token();

    // Directed words under the reset limit.
    push_text("[x1]:\n");                      // every single-character token
    push_text("0.0.0.255 ");                   // octet extremes
    push_text("256.1.1.1\t1.2.3.4.5 1.2.3 ");  // octet too big, too many and too few groups
    push_text("1234.1.1.1 ");                  // four digits in a group
    push_text("a.b-c. z.-y ");                 // trailing dot kept; label led by a hyphen fails
    push_text("\"a [b]\"\n");                  // delimiters inside quotes
    push_byte(8'h00);                          // bytes that start only an error token
    push_byte(8'hFF);
    push_byte(CH_SPACE);
    push_text("\"ab");                         // end of input inside a string
    push_end(8'hFF);
    push_end(8'h00);                           // end while idle
    push_text("Zz9");                          // end closes a pending identifier
    push_end(8'h5A);
    gen_random(char_q.size() + PhaseWords);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Three limits that fail every domain, a middle value, a random one and
    // finally the top value written back.
    limits    = '{8'd2, 8'd0, 8'd1, 8'd40, 8'd0, LimitReset};
    limits[4] = 8'($urandom_range(3, 254));
    for (int p = 0; p < 6; p++) begin
      wait_idle();
      write_limit(limits[p]);
      @(negedge clk_i);
      gen_random(PhaseWords);
      if (p == 5) gen_long_tokens();
    end

    wait_idle();
    $display("Run covered %0d input words and %0d tokens over %0d limit settings,",
             words_taken, tokens_seen, limits_used);
    $display("with random gaps on both channels and domains at the top length limit.");
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/ctl_pkg.sv
rtl/ctl_if.sv
rtl/ctl_front.sv
rtl/ctl_back.sv
rtl/ctl_outq.sv
rtl/config_token_lexer.sv
tb/config_token_lexer_tb.sv
